FILE: sv/acs_pkg.sv
`timescale 1ns / 1ps

package acs_pkg;

	// input item commands
	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_RX   = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} acs_cmd_t;

	// converter and scaling constants
	localparam int unsigned REF_UV = 2500000;
	localparam int unsigned MV_DIV = 1000;
	localparam logic [15:0] CMD_MANUAL = (16'd1 << 12) | (16'd1 << 11) | (16'd1 << 6);
	localparam int unsigned TX_CH_LSB = 7;

	// fixed result field widths
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned CHAN_W  = 4;
	localparam int unsigned RAW_W   = 10;
	localparam int unsigned MV_W    = 13;
	localparam int unsigned RCH_W   = 8;

endpackage

FILE: sv/adc_channel_scan_sequencer.sv
`timescale 1ns / 1ps

// channel      signals                                          transfer when
// command in   start, busy, cmd, rx_word, link_error,           start && !busy
//              read_channel
// result out   done, tx_valid, tx_command, sample_valid,        done (one cycle)
//              sample_channel, sample_raw, read_millivolts,
//              read_error, halted_flag
// config in    cfg_valid, cfg_ready, cfg_data                   cfg_valid && cfg_ready
//
// Tick, received word, nop and bad-channel read: result in the cycle after the
// transfer. A tick that issues a command keeps busy high while the pointer
// walks to the next enabled channel, one channel per cycle.
// A valid read passes the store read, scaler start, raw capture, multiply,
// shift and result registers in that order; busy stays high until its result.
// Reset clears pointer, flags and the sample valid bits; unwritten samples
// read as zero. The receiver cannot stall results.
module adc_channel_scan_sequencer import acs_pkg::*; #(
	parameter int NUM_CHANNELS = 16,
	parameter int SAMPLE_BITS  = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [WORD_W-1:0] rx_word,
	input  logic              link_error,
	input  logic [RCH_W-1:0]  read_channel,
	output logic              done,
	output logic              tx_valid,
	output logic [WORD_W-1:0] tx_command,
	output logic              sample_valid,
	output logic [CHAN_W-1:0] sample_channel,
	output logic [RAW_W-1:0]  sample_raw,
	output logic [MV_W-1:0]   read_millivolts,
	output logic              read_error,
	output logic              halted_flag,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WORD_W-1:0] cfg_data
);

	localparam int unsigned CH_W       = $clog2(NUM_CHANNELS);
	localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
	localparam int unsigned LSB_UV     = 2 * REF_UV / SAMPLE_MAX;
	localparam int unsigned MV_MAX     = SAMPLE_MAX * LSB_UV / MV_DIV;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADV,
		ST_READ,
		ST_SCALE
	} state_t;

	state_t                   state_q;
	logic [CH_W-1:0]          ptr_q;
	logic                     tbusy_q;
	logic                     halted_q;
	logic [WORD_W-1:0]        mask_q;
	logic [NUM_CHANNELS-1:0]  vld_q;
	logic [SAMPLE_BITS-1:0]   store_q [NUM_CHANNELS];
	logic [SAMPLE_BITS-1:0]   rd_q;
	logic                     rd_vld_q;
	logic                     scale_start_q;

	logic                     done_q;
	logic                     tx_valid_q;
	logic [WORD_W-1:0]        tx_command_q;
	logic                     sample_valid_q;
	logic [CHAN_W-1:0]        sample_channel_q;
	logic [RAW_W-1:0]         sample_raw_q;
	logic [MV_W-1:0]          read_mv_q;
	logic                     read_error_q;
	logic                     halted_flag_q;

	logic                     accept;
	logic [CHAN_W-1:0]        rx_ch;
	logic [SAMPLE_BITS-1:0]   rx_val;
	logic                     rx_ch_ok;
	logic                     rd_ch_ok;
	logic                     store_we;
	logic [NUM_CHANNELS-1:0]  mask_eff;
	logic [CH_W-1:0]          ptr_next;
	logic                     scale_done;
	logic [MV_W-1:0]          scale_mv;

	assign accept   = start && !busy;
	assign rx_ch    = rx_word[WORD_W-1 -: CHAN_W];
	assign rx_val   = rx_word[11 -: SAMPLE_BITS];
	assign rx_ch_ok = ({1'b0, rx_ch} < (CHAN_W + 1)'(NUM_CHANNELS));
	assign rd_ch_ok = (read_channel < RCH_W'(NUM_CHANNELS));
	assign store_we = accept && (cmd == CMD_RX) && !link_error && rx_ch_ok;

	// an empty mask enables every channel
	always_comb begin
		mask_eff = mask_q[NUM_CHANNELS-1:0];
		if (mask_eff == '0) begin
			mask_eff = '1;
		end
	end

	// cyclic pointer increment
	assign ptr_next = (ptr_q == CH_W'(NUM_CHANNELS - 1)) ? '0 : ptr_q + CH_W'(1);

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= cfg_data;
		end
	end

	// sample store with registered read, captured at the command transfer
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[rx_ch[CH_W-1:0]] <= rx_val;
		end
		if (accept) begin
			rd_q <= store_q[read_channel[CH_W-1:0]];
		end
	end

	// per-channel written marks, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (store_we) begin
				vld_q[rx_ch[CH_W-1:0]] <= 1'b1;
			end
			if (accept) begin
				rd_vld_q <= vld_q[read_channel[CH_W-1:0]];
			end
		end
	end

	// millivolt scaler
	acs_scale #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scale_start_q),
		.raw       (rd_vld_q ? rd_q : '0),
		.done      (scale_done),
		.millivolts(scale_mv)
	);

	// main sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ptr_q         <= '0;
			tbusy_q       <= 1'b0;
			halted_q      <= 1'b0;
			scale_start_q <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q        <= 1'b0;
			scale_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tx_valid_q       <= 1'b0;
						tx_command_q     <= '0;
						sample_valid_q   <= 1'b0;
						sample_channel_q <= '0;
						sample_raw_q     <= '0;
						read_mv_q        <= '0;
						read_error_q     <= 1'b0;
						halted_flag_q    <= halted_q;
						done_q           <= 1'b1;
						unique case (cmd)
							CMD_TICK: begin
								if (!tbusy_q && !halted_q) begin
									tx_valid_q   <= 1'b1;
									tx_command_q <= CMD_MANUAL |
										(WORD_W'(ptr_q) << TX_CH_LSB);
									tbusy_q      <= 1'b1;
									state_q      <= ST_ADV;
								end
							end
							CMD_RX: begin
								if (link_error) begin
									halted_q      <= 1'b1;
									halted_flag_q <= 1'b1;
								end else if (rx_ch_ok) begin
									tbusy_q          <= 1'b0;
									sample_valid_q   <= 1'b1;
									sample_channel_q <= rx_ch;
									sample_raw_q     <= RAW_W'(rx_val);
								end
							end
							CMD_READ: begin
								if (rd_ch_ok) begin
									// result comes from the scaler later
									done_q  <= 1'b0;
									state_q <= ST_READ;
								end else begin
									read_error_q <= 1'b1;
								end
							end
							CMD_NOP: begin
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADV: begin
					// walk one channel per cycle to the next enabled one
					ptr_q <= ptr_next;
					if (mask_eff[ptr_next]) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					scale_start_q <= 1'b1;
					state_q       <= ST_SCALE;
				end
				ST_SCALE: begin
					if (scale_done) begin
						read_mv_q <= scale_mv;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign tx_valid        = tx_valid_q;
	assign tx_command      = tx_command_q;
	assign sample_valid    = sample_valid_q;
	assign sample_channel  = sample_channel_q;
	assign sample_raw      = sample_raw_q;
	assign read_millivolts = read_mv_q;
	assign read_error      = read_error_q;
	assign halted_flag     = halted_flag_q;

	// an issued command always leaves a transfer outstanding
	a_tx_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && tx_valid |-> tbusy_q)
		else $error("command issued without outstanding transfer");

	// halt is sticky until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("scan halt cleared without reset");

	// scaled value stays within full scale
	a_mv_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (read_millivolts <= MV_W'(MV_MAX)))
		else $error("millivolt result above full scale");

	// pointer walk ends on an enabled channel
	a_ptr_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV) && mask_eff[ptr_next] |=> mask_eff[ptr_q])
		else $error("scan pointer stopped on a disabled channel");

endmodule

FILE: sv/acs_scale.sv
`timescale 1ns / 1ps

// raw sample to millivolts: multiply by a ceiling reciprocal of LSB_UV / MV_DIV
// scaled by 2^RECIP_SH, then keep the bits above RECIP_SH; the reciprocal error
// stays below one part in MV_DIV * SAMPLE_MAX, so the floor is exact
module acs_scale import acs_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] raw,
	output logic                   done,
	output logic [MV_W-1:0]        millivolts
);

	localparam int unsigned       SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
	localparam int unsigned       LSB_UV     = 2 * REF_UV / SAMPLE_MAX;
	localparam int unsigned       RECIP_SH   = SAMPLE_BITS + 10;
	localparam longint unsigned   RECIP      =
		((64'(LSB_UV) << RECIP_SH) + 64'(MV_DIV) - 64'd1) / 64'(MV_DIV);
	localparam int unsigned       PROD_W     = RECIP_SH + MV_W;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_MUL,
		SC_OUT
	} sc_state_t;

	sc_state_t              state_q;
	logic [SAMPLE_BITS-1:0] raw_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   done_q;
	logic [MV_W-1:0]        mv_q;

	// sequencer: capture, multiply, shift out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SC_IDLE: begin
					if (start) begin
						raw_q   <= raw;
						state_q <= SC_MUL;
					end
				end
				SC_MUL: begin
					prod_q  <= PROD_W'(raw_q) * PROD_W'(RECIP);
					state_q <= SC_OUT;
				end
				SC_OUT: begin
					// quotient sits above the reciprocal scaling
					mv_q    <= prod_q[RECIP_SH +: MV_W];
					done_q  <= 1'b1;
					state_q <= SC_IDLE;
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign millivolts = mv_q;

endmodule

FILE: tb/tb_adc_channel_scan_sequencer.sv
`timescale 1ns / 1ps

module tb_adc_channel_scan_sequencer;
	import acs_pkg::*;

	localparam int NUM_CHANNELS = 16;
	localparam int SAMPLE_BITS = 10;
	localparam int unsigned LSB_UV = 2 * REF_UV / ((1 << SAMPLE_BITS) - 1);
	localparam logic [15:0] ALL_CHANNELS = 16'((32'd1 << NUM_CHANNELS) - 1);
	localparam int SETTLE_CYCLES = NUM_CHANNELS + 8;
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 215;
	localparam int HALT_ITEMS = 40;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		acs_cmd_t          cmd;
		logic [WORD_W-1:0] rx_word;
		logic              link_error;
		logic [RCH_W-1:0]  read_channel;
	} scan_req_t;

	typedef struct packed {
		logic              tx_valid;
		logic [WORD_W-1:0] tx_command;
		logic              sample_valid;
		logic [CHAN_W-1:0] sample_channel;
		logic [RAW_W-1:0]  sample_raw;
		logic [MV_W-1:0]   read_millivolts;
		logic              read_error;
		logic              halted_flag;
	} scan_resp_t;

	// scanner state mirror and the queue of outputs still due
	class scan_checker;
		logic [15:0] enable_mask;
		logic [3:0] scan_ptr;
		logic [3:0] last_tx_ch;
		bit xfer_busy;
		bit halted;
		logic [SAMPLE_BITS-1:0] samples [NUM_CHANNELS];
		scan_resp_t due_outputs [$];
		int accepted, checked, mismatches, issued, stored, bad_reads, mask_writes;

		function new();
			enable_mask = 16'hFFFF;
			scan_ptr = '0;
			last_tx_ch = '0;
			xfer_busy = 0;
			halted = 0;
			foreach (samples[i])
				samples[i] = '0;
		endfunction

		function int pending();
			return due_outputs.size();
		endfunction

		function void set_mask(logic [15:0] m);
			enable_mask = m;
			mask_writes++;
		endfunction

		// next enabled channel after p, wrapping; empty mask enables all
		function logic [3:0] step_ptr(logic [3:0] p);
			logic [15:0] m;
			int i;
			m = enable_mask & ALL_CHANNELS;
			if (m == '0)
				m = ALL_CHANNELS;
			for (i = 0; i < NUM_CHANNELS; i++) begin
				p = (int'(p) + 1 >= NUM_CHANNELS) ? 4'd0 : p + 4'd1;
				if (m[p])
					break;
			end
			return p;
		endfunction

		// predict the output of one transfer and update the mirror
		function void note_item(scan_req_t req);
			scan_resp_t exp_out;
			int ch;
			logic [SAMPLE_BITS-1:0] raw;
			exp_out = '0;
			accepted++;
			case (req.cmd)
				CMD_TICK: begin
					if (!xfer_busy && !halted) begin
						exp_out.tx_valid = 1'b1;
						exp_out.tx_command = CMD_MANUAL | (WORD_W'(scan_ptr) << TX_CH_LSB);
						last_tx_ch = scan_ptr;
						xfer_busy = 1;
						scan_ptr = step_ptr(scan_ptr);
						issued++;
					end
				end
				CMD_RX: begin
					if (req.link_error) begin
						halted = 1;
					end else begin
						ch = int'(req.rx_word[15:12]);
						if (ch < NUM_CHANNELS) begin
							raw = SAMPLE_BITS'(req.rx_word >> (12 - SAMPLE_BITS));
							samples[ch] = raw;
							xfer_busy = 0;
							exp_out.sample_valid = 1'b1;
							exp_out.sample_channel = CHAN_W'(ch);
							exp_out.sample_raw = RAW_W'(raw);
							stored++;
						end
					end
				end
				CMD_READ: begin
					ch = int'(req.read_channel);
					if (ch >= NUM_CHANNELS) begin
						exp_out.read_error = 1'b1;
						bad_reads++;
					end else begin
						exp_out.read_millivolts = MV_W'(int'(samples[ch]) * LSB_UV / MV_DIV);
					end
				end
				default: ;
			endcase
			exp_out.halted_flag = halted;
			due_outputs.push_back(exp_out);
		endfunction

		function void compare_field(string name, logic [31:0] e, logic [31:0] a,
			inout string bad);
			if (a !== e)
				bad = {bad, $sformatf(" %s exp %0h got %0h", name, e, a)};
		endfunction

		// compare one output against the oldest prediction
		function void check_output(scan_resp_t got);
			scan_resp_t e;
			string bad;
			if (due_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected output with nothing pending: %h", got);
				return;
			end
			e = due_outputs.pop_front();
			bad = "";
			compare_field("tx_valid", e.tx_valid, got.tx_valid, bad);
			compare_field("tx_command", e.tx_command, got.tx_command, bad);
			compare_field("sample_valid", e.sample_valid, got.sample_valid, bad);
			compare_field("sample_channel", e.sample_channel, got.sample_channel, bad);
			compare_field("sample_raw", e.sample_raw, got.sample_raw, bad);
			compare_field("read_millivolts", e.read_millivolts, got.read_millivolts, bad);
			compare_field("read_error", e.read_error, got.read_error, bad);
			compare_field("halted_flag", e.halted_flag, got.halted_flag, bad);
			checked++;
			if (bad != "") begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch on output %0d:%s", checked, bad);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] cmd;
	logic [WORD_W-1:0] rx_word;
	logic link_error;
	logic [RCH_W-1:0] read_channel;
	logic done;
	logic tx_valid;
	logic [WORD_W-1:0] tx_command;
	logic sample_valid;
	logic [CHAN_W-1:0] sample_channel;
	logic [RAW_W-1:0] sample_raw;
	logic [MV_W-1:0] read_millivolts;
	logic read_error;
	logic halted_flag;
	logic cfg_valid;
	logic cfg_ready;
	logic [WORD_W-1:0] cfg_data;

	scan_checker sb = new();
	int burst_left = 0;
	int idle_cycles = 0;

	adc_channel_scan_sequencer #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (.*);

	always #6 clk = ~clk;

	// monitor: outputs first, then the command transfer of this edge
	always @(posedge clk) begin
		scan_req_t req;
		scan_resp_t got;
		if (arst_n) begin
			if (done) begin
				got.tx_valid = tx_valid;
				got.tx_command = tx_command;
				got.sample_valid = sample_valid;
				got.sample_channel = sample_channel;
				got.sample_raw = sample_raw;
				got.read_millivolts = read_millivolts;
				got.read_error = read_error;
				got.halted_flag = halted_flag;
				sb.check_output(got);
			end
			if (start && !busy) begin
				req.cmd = acs_cmd_t'(cmd);
				req.rx_word = rx_word;
				req.link_error = link_error;
				req.read_channel = read_channel;
				sb.note_item(req);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic scan_req_t mk(acs_cmd_t c, logic [15:0] w, logic le, logic [7:0] ch);
		scan_req_t r;
		r.cmd = c;
		r.rx_word = w;
		r.link_error = le;
		r.read_channel = ch;
		return r;
	endfunction

	// sender bursts: random burst length, random gap between bursts
	task automatic pace();
		int gap;
		int sel;
		if (burst_left == 0) begin
			sel = $urandom_range(0, 9);
			if (sel < 4)
				gap = 0;
			else if (sel < 9)
				gap = $urandom_range(1, 4);
			else
				gap = $urandom_range(5, 24);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// hold the command until the edge that transfers it
	task automatic send_item(scan_req_t req);
		start <= 1'b1;
		cmd <= req.cmd;
		rx_word <= req.rx_word;
		link_error <= req.link_error;
		read_channel <= req.read_channel;
		do @(posedge clk); while (busy);
	endtask

	// mostly tick / reply-to-issued-channel / read traffic, plus noise
	task automatic make_item(output scan_req_t req, input bit allow_halt);
		int sel;
		sel = $urandom_range(0, 99);
		req.rx_word = 16'($urandom);
		req.read_channel = 8'($urandom);
		req.link_error = 1'($urandom);
		if (sel < 35) begin
			req.cmd = CMD_TICK;
		end else if (sel < 65) begin
			req.cmd = CMD_RX;
			if ($urandom_range(0, 9) < 7)
				req.rx_word[15:12] = sb.last_tx_ch;
			if ($urandom_range(0, 7) == 0)
				req.rx_word[11:2] = $urandom_range(0, 1) ? '1 : '0;
		end else if (sel < 88) begin
			req.cmd = CMD_READ;
			if ($urandom_range(0, 9) < 8)
				req.read_channel = 8'($urandom_range(0, NUM_CHANNELS - 1));
		end else if (sel < 94) begin
			req.cmd = CMD_NOP;
		end else begin
			req.cmd = acs_cmd_t'($urandom_range(0, 3));
		end
		// link errors halt for good, so they only come in the last phase
		if (req.cmd == CMD_RX)
			req.link_error = allow_halt && ($urandom_range(0, 7) == 0);
	endtask

	// mask write once the scanner is quiet, including its pointer walk
	task automatic write_mask(logic [15:0] mask);
		start <= 1'b0;
		while (sb.pending() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mask;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_mask(mask);
	endtask

	initial begin
		scan_req_t req;
		scan_req_t directed [$];
		logic [15:0] plan [8];
		int p;
		int n;

		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_NOP;
		rx_word <= '0;
		link_error <= 1'b0;
		read_channel <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads of cleared store, bad channels, nop, busy tick, value extremes
		directed.push_back(mk(CMD_READ, 16'h0000, 1'b0, 8'd0));
		directed.push_back(mk(CMD_READ, 16'hFFFF, 1'b1, 8'd255));
		directed.push_back(mk(CMD_READ, 16'h0000, 1'b0, 8'd16));
		directed.push_back(mk(CMD_NOP, 16'hFFFF, 1'b1, 8'd255));
		directed.push_back(mk(CMD_TICK, 16'hFFFF, 1'b1, 8'd0));
		directed.push_back(mk(CMD_TICK, 16'h0000, 1'b0, 8'd0));
		directed.push_back(mk(CMD_RX, 16'h0FFF, 1'b0, 8'd0));
		directed.push_back(mk(CMD_READ, 16'h0000, 1'b0, 8'd0));
		directed.push_back(mk(CMD_TICK, 16'h0000, 1'b0, 8'd0));
		directed.push_back(mk(CMD_RX, 16'hF003, 1'b0, 8'd0));
		directed.push_back(mk(CMD_READ, 16'h0000, 1'b0, 8'd15));
		directed.push_back(mk(CMD_TICK, 16'h0000, 1'b0, 8'd0));
		directed.push_back(mk(CMD_RX, 16'hFFFF, 1'b0, 8'd0));
		directed.push_back(mk(CMD_READ, 16'h0000, 1'b0, 8'd15));
		directed.push_back(mk(CMD_RX, 16'h1800, 1'b0, 8'd0));
		directed.push_back(mk(CMD_READ, 16'h0000, 1'b0, 8'd1));
		directed.push_back(mk(CMD_READ, 16'h0000, 1'b0, 8'h80));
		foreach (directed[i]) begin
			pace();
			send_item(directed[i]);
		end

		// mask settings: single channels, empty, full, ends, random
		plan[0] = 16'h0001;
		plan[1] = 16'h0000;
		plan[2] = 16'h8000;
		plan[3] = 16'($urandom);
		plan[4] = 16'hFFFF;
		plan[5] = 16'h8001;
		plan[6] = 16'($urandom & $urandom);
		plan[7] = 16'h0004;
		for (p = 0; p < 8; p++) begin
			write_mask(plan[p]);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				make_item(req, 1'b0);
				pace();
				send_item(req);
			end
		end

		// link error halts scanning; ticks then issue nothing
		pace();
		send_item(mk(CMD_RX, 16'($urandom), 1'b1, 8'($urandom)));
		for (n = 0; n < HALT_ITEMS; n++) begin
			make_item(req, 1'b1);
			pace();
			send_item(req);
		end
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands, %0d outputs checked, %0d scan words issued, %0d samples",
			sb.accepted, sb.checked, sb.issued, sb.stored);
		$display("%0d mask writes, %0d out-of-range reads, scanning %s at end",
			sb.mask_writes, sb.bad_reads, sb.halted ? "halted" : "running");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			if (sb.pending() != 0)
				$display("%0d predicted outputs never arrived", sb.pending());
			$display("%0d mismatches", sb.mismatches);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/acs_pkg.sv
sv/acs_scale.sv
sv/adc_channel_scan_sequencer.sv
tb/tb_adc_channel_scan_sequencer.sv
